/* hw/rtl/ggbs_pkg.sv */
`default_nettype none
package ggbs_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_GRAD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd2;

  // item kinds on s_axis_tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] HEIGHT_MIN   = 13'd3;
  localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

  // floor(x / 9) for x < 2304 as (x * 7282) >> 16
  localparam logic [12:0] RECIP_9 = 13'd7282;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = 3;
  localparam int OUTQ_CW    = 4;

  typedef struct packed {
    logic produce;
    logic last;
    logic interior;
  } ctrl_t;

  typedef struct packed {
    logic       last;
    logic [7:0] pix;
  } out_word_t;

endpackage
`default_nettype wire

/* hw/rtl/ggbs_outq.sv */
`default_nettype none
module ggbs_outq (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  ggbs_pkg::out_word_t    push_word,
  output logic                   tvalid,
  input  wire                    tready,
  output ggbs_pkg::out_word_t    word,
  output logic [3:0]             count
);
  import ggbs_pkg::*;

  out_word_t            slots [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr;
  logic [OUTQ_AW-1:0]   rd_ptr;
  logic                 pop;

  assign tvalid = (count != '0);
  assign pop    = tvalid && tready;
  assign word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gradient_gated_box_smoothing_core.sv */
`default_nettype none
// a result to m_axis passes line reads, window, square/sum and queue; throughput: one
// word per cycle while the output queue has room; each line memory takes one read and
// one write a cycle; the first w_act+1 words of a frame give no result, drain words
// flush the tail; reset clears counters, window and output queue; line memories are
// not cleared; stale entries only reach border results, which pass the centre through
module gradient_gated_box_smoothing_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire         s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [12:0] cfg_data
);
  import ggbs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int FW = $clog2(MAX_WIDTH + 2);

  // configuration
  logic [9:0]  grad_thr;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [CW-1:0] w_act;
  logic [12:0]   h_act;

  always_comb begin
    if (frame_width < 11'd3) w_act = CW'(3);
    else if (int'(frame_width) > MAX_WIDTH) w_act = CW'(MAX_WIDTH);
    else w_act = CW'(frame_width);
    if (frame_height < HEIGHT_MIN) h_act = HEIGHT_MIN;
    else if (frame_height > HEIGHT_MAX) h_act = HEIGHT_MAX;
    else h_act = frame_height;
  end

  // frame counters
  logic [AW-1:0] col_cnt;
  logic [11:0]   row_cnt;
  logic          tail;
  logic [FW-1:0] fill;
  logic [AW-1:0] out_col;
  logic [11:0]   out_row;

  // pipeline
  logic          s1_v, s2_v, s3_v;
  ctrl_t         s1_ctrl, s2_ctrl, s3_ctrl;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_pix;
  logic [7:0]    above_q, mid_q;
  logic [7:0]    win [3][3];

  logic [7:0]  line_a [MAX_WIDTH];
  logic [7:0]  line_b [MAX_WIDTH];

  logic [OUTQ_CW-1:0] q_count;
  logic [OUTQ_CW-1:0] in_flight;
  logic        go, take;
  logic [7:0]  pix0;
  ctrl_t       ctrl0;
  logic [CW-1:0] col_inc, ocol_inc;
  logic [12:0]   row_inc, orow_inc;
  logic          wrap, cfg_restart;

  assign in_flight     = OUTQ_CW'(s1_v) + OUTQ_CW'(s2_v) + OUTQ_CW'(s3_v);
  assign s_axis_tready = (q_count + in_flight) < OUTQ_CW'(OUTQ_DEPTH);
  assign go            = s_axis_tvalid && s_axis_tready;
  // a drain word counts only once the frame is in its tail
  assign take          = go && (tail || (s_axis_tuser == OP_PIXEL));
  assign pix0          = tail ? 8'd0 : s_axis_tdata;

  assign col_inc  = CW'(col_cnt) + CW'(1);
  assign wrap     = (col_inc >= w_act);
  assign row_inc  = 13'(row_cnt) + 13'd1;
  assign ocol_inc = CW'(out_col) + CW'(1);
  assign orow_inc = 13'(out_row) + 13'd1;
  assign cfg_restart = cfg_we &&
                       ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    ctrl0.produce  = (fill == (FW'(w_act) + FW'(1)));
    ctrl0.last     = ctrl0.produce && (ocol_inc == w_act) && (orow_inc == h_act);
    ctrl0.interior = (out_col != '0) && (ocol_inc < w_act) &&
                     (out_row != '0) && (orow_inc < h_act);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grad_thr     <= '0;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAD_THRESHOLD: grad_thr     <= cfg_data[9:0];
        REG_FRAME_WIDTH:    frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT:   frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart || (take && ctrl0.last)) begin
      col_cnt <= '0;
      row_cnt <= '0;
      tail    <= 1'b0;
      fill    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (wrap) begin
        col_cnt <= '0;
        if (!tail) begin
          if (row_inc >= h_act) begin
            row_cnt <= '0;
            tail    <= 1'b1;
          end else begin
            row_cnt <= row_inc[11:0];
          end
        end
      end else begin
        col_cnt <= col_inc[AW-1:0];
      end
      if (!ctrl0.produce) begin
        fill <= fill + FW'(1);
      end else if (ocol_inc == w_act) begin
        out_col <= '0;
        out_row <= orow_inc[11:0];
      end else begin
        out_col <= ocol_inc[AW-1:0];
      end
    end
  end

  // line memories: read at acceptance, shift down a line in the cycle after
  always_ff @(posedge clk) begin
    if (take) above_q <= line_a[col_cnt];
    if (s1_v) line_a[s1_addr] <= mid_q;
  end

  always_ff @(posedge clk) begin
    if (take) mid_q <= line_b[col_cnt];
    if (s1_v) line_b[s1_addr] <= s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= take;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl <= ctrl0;
    s1_addr <= col_cnt;
    s1_pix  <= pix0;
    s2_ctrl <= s1_ctrl;
    s3_ctrl <= s2_ctrl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_v) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= above_q;
      win[1][2] <= mid_q;
      win[2][2] <= s1_pix;
    end
  end

  // gradient squares, neighbourhood sum and threshold square
  logic signed [8:0]  dx, dy;
  logic signed [17:0] dx_sq, dy_sq;
  logic [19:0] thr_sq_c;
  logic [11:0] sum_c;
  logic [15:0] sq_x, sq_y;
  logic [19:0] thr_sq;
  logic [11:0] sum_q;
  logic [7:0]  centre;

  assign dx       = $signed({1'b0, win[1][2]}) - $signed({1'b0, win[1][0]});
  assign dy       = $signed({1'b0, win[2][1]}) - $signed({1'b0, win[0][1]});
  assign dx_sq    = dx * dx;
  assign dy_sq    = dy * dy;
  assign thr_sq_c = 20'(grad_thr) * 20'(grad_thr);

  always_comb begin
    sum_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum_c = sum_c + 12'(win[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_x   <= dx_sq[15:0];
    sq_y   <= dy_sq[15:0];
    thr_sq <= thr_sq_c;
    sum_q  <= sum_c;
    centre <= win[1][1];
  end

  // gate and mean
  logic [16:0] grad_sq;
  logic [24:0] mean_prod;
  logic        smooth;
  logic        push;
  out_word_t   push_word;
  out_word_t   q_word;

  assign grad_sq   = 17'(sq_x) + 17'(sq_y);
  assign mean_prod = 25'(sum_q) * 25'(RECIP_9);
  assign smooth    = s3_ctrl.interior && (20'(grad_sq) >= thr_sq);
  assign push      = s3_v && s3_ctrl.produce;

  always_comb begin
    push_word.last = s3_ctrl.last;
    push_word.pix  = smooth ? mean_prod[23:16] : centre;
  end

  ggbs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .word      (q_word),
    .count     (q_count)
  );

  assign m_axis_tdata = q_word.pix;
  assign m_axis_tlast = q_word.last;

  // the credit check must keep the queue from overflowing
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count < OUTQ_CW'(OUTQ_DEPTH)))
    else $error("result pushed into a full output queue");

  // line address stays inside the active row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(col_cnt) < w_act)
    else $error("column counter beyond frame width");

  // write-back of the previous word never meets the current read, except across frames
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (take && s1_v && !s1_ctrl.last) |-> (s1_addr != col_cnt))
    else $error("line memory read and write at the same entry");

  // the final result of a frame restarts all frame counters
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && ctrl0.last && !cfg_we) |=>
      (col_cnt == '0) && (row_cnt == '0) && !tail && (fill == '0))
    else $error("frame state not restarted after last result");

endmodule
`default_nettype wire
